// ===== rtl/q2r_pkg.sv =====
// q2r_pkg: shared types and constants for the quaternion to rotation matrix block
// no dependencies
`timescale 1ns / 1ps
package q2r_pkg;

  localparam int IN_W = 16;
  localparam int OUT_W = 16;

  typedef struct packed {
    logic signed [IN_W-1:0] quat_x;
    logic signed [IN_W-1:0] quat_y;
    logic signed [IN_W-1:0] quat_z;
    logic signed [IN_W-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] col0_row0;
    logic signed [OUT_W-1:0] col0_row1;
    logic signed [OUT_W-1:0] col0_row2;
    logic signed [OUT_W-1:0] col1_row0;
    logic signed [OUT_W-1:0] col1_row1;
    logic signed [OUT_W-1:0] col1_row2;
    logic signed [OUT_W-1:0] col2_row0;
    logic signed [OUT_W-1:0] col2_row1;
    logic signed [OUT_W-1:0] col2_row2;
    logic                    zero_norm;
  } matrix_t;

  // pipeline stall control handed to each stage
  typedef struct packed {
    logic advance;
  } stage_ctl_t;

endpackage

// ===== rtl/quaternion_to_rotation_matrix.sv =====
// quaternion_to_rotation_matrix: top level, front end, nine dividers, output skid
// uses q2r_pkg, q2r_front, q2r_divider
//
//  port          dir  handshake          word
//  in_*          in   in_valid/in_ready  q2r_pkg::quat_t
//  out_*         out  out_valid/out_ready q2r_pkg::matrix_t
//
// one quaternion per cycle while the skid slot is empty; the path runs through three front stages,
// OUT_FRAC_BITS + 2 divider stages, all but the last giving one quotient bit, and the output register
// synchronous reset clears all valid bits; payload registers are not reset
// the whole pipeline holds in every cycle that the skid slot is full, including the
// cycle in which the skid word moves to the output register
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  q2r_pkg::quat_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output q2r_pkg::matrix_t out_data
);
  localparam int IW = q2r_pkg::IN_W;
  localparam int NW = 2 * IW + 2;
  localparam int OW = q2r_pkg::OUT_W;

  q2r_pkg::stage_ctl_t ctl;
  logic skid_full;
  logic pipe_valid;
  q2r_pkg::matrix_t pipe_word, skid_word;

  // pipeline moves whenever the skid slot is empty
  assign ctl.advance = !skid_full;
  assign in_ready    = ctl.advance;

  logic          fv;
  logic [NW-1:0] norm;
  logic [NW-1:0] nm [9];
  logic [8:0]    nn;
  logic          zero;

  q2r_front #(.IW(IW)) u_front (
    .clk(clk), .rst(rst), .ctl(ctl),
    .in_valid(in_valid && in_ready),
    .qx(in_data.quat_x), .qy(in_data.quat_y),
    .qz(in_data.quat_z), .qw(in_data.quat_w),
    .out_valid(fv), .norm(norm), .num_mag(nm), .num_neg(nn), .zero(zero)
  );

  // zero norm: divide by 1 with numerators forced to 1 on the diagonal and 0 elsewhere
  logic [NW-1:0]      den;
  assign den = zero ? NW'(1) : norm;

  logic [8:0]         dv;
  logic [OUT_FRAC_BITS:0] q [9];
  logic [8:0]         qn;
  logic               zside [9];

  for (genvar i = 0; i < 9; i++) begin : g_div
    q2r_divider #(.NW(NW), .FRAC(OUT_FRAC_BITS), .SW(1)) u_div (
      .clk(clk), .rst(rst), .ctl(ctl),
      .in_valid(fv),
      .mag(zero ? ((i == 0 || i == 4 || i == 8) ? NW'(1) : '0) : nm[i]),
      .den(den), .neg(zero ? 1'b0 : nn[i]), .side(zero),
      .out_valid(dv[i]), .quot(q[i]), .quot_neg(qn[i]), .out_side(zside[i])
    );
  end

  logic signed [OW-1:0] ent [9];
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      ent[i] = OW'(qn[i] ? -{{(OW){1'b0}}, q[i]} : {{(OW){1'b0}}, q[i]});
    end
    pipe_word.col0_row0 = ent[0];
    pipe_word.col0_row1 = ent[1];
    pipe_word.col0_row2 = ent[2];
    pipe_word.col1_row0 = ent[3];
    pipe_word.col1_row1 = ent[4];
    pipe_word.col1_row2 = ent[5];
    pipe_word.col2_row0 = ent[6];
    pipe_word.col2_row1 = ent[7];
    pipe_word.col2_row2 = ent[8];
    pipe_word.zero_norm = zside[0];
  end
  assign pipe_valid = dv[0];

  // output register plus one skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        if (skid_full) begin
          out_valid <= 1'b1;
          skid_full <= 1'b0;
        end else begin
          out_valid <= pipe_valid;
        end
      end else if (pipe_valid && !skid_full) begin
        skid_full <= 1'b1;
      end
    end
    if (!out_valid || out_ready) begin
      out_data <= skid_full ? skid_word : pipe_word;
    end else if (pipe_valid && !skid_full) begin
      skid_word <= pipe_word;
    end
  end

  a_divs_aligned: assert property (@(posedge clk) disable iff (rst)
    dv[0] == dv[8]) else $error("divider lanes out of step");
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid) else $error("skid full with no output word");
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (skid_full && !out_ready) |=> skid_full) else $error("skid word lost");

endmodule

// ===== rtl/q2r_divider.sv =====
// q2r_divider: pipelined restoring divider, one quotient bit per stage but the last, which rounds;
// gives round(mag * 2^FRAC / n) with ties away from zero; uses q2r_pkg
`timescale 1ns / 1ps
module q2r_divider #(
  parameter int NW = 34,
  parameter int FRAC = 14,
  parameter int SW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  q2r_pkg::stage_ctl_t ctl,
  input  logic                in_valid,
  input  logic [NW-1:0]       mag,
  input  logic [NW-1:0]       den,
  input  logic                neg,
  input  logic [SW-1:0]       side,
  output logic                out_valid,
  output logic [FRAC:0]       quot,
  output logic                quot_neg,
  output logic [SW-1:0]       out_side
);
  localparam int ST = FRAC + 2;

  // stage 0 takes the integer bit, stages 1..FRAC fractional bits, last rounds
  logic [NW-1:0] r     [ST+1];
  logic [NW-1:0] d     [ST+1];
  logic [FRAC+1:0] q   [ST+1];
  logic          v     [ST+1];
  logic          s     [ST+1];
  logic [SW-1:0] sd    [ST+1];

  assign r[0]  = mag;
  assign d[0]  = den;
  assign q[0]  = '0;
  assign v[0]  = in_valid;
  assign s[0]  = neg;
  assign sd[0] = side;

  for (genvar k = 0; k < ST; k++) begin : g_st
    logic [NW-1:0] rn;
    logic [FRAC+1:0] qn;
    always_comb begin
      rn = r[k];
      qn = q[k];
      if (k == 0) begin
        if (r[k] >= d[k]) begin
          qn = {{(FRAC+1){1'b0}}, 1'b1};
          rn = r[k] - d[k];
        end
      end else if (k <= FRAC) begin
        if (r[k] >= d[k] - r[k]) begin
          qn = {q[k][FRAC:0], 1'b1};
          rn = r[k] - (d[k] - r[k]);
        end else begin
          qn = {q[k][FRAC:0], 1'b0};
          rn = r[k] + r[k];
        end
      end else begin
        if (r[k] >= d[k] - r[k]) qn = q[k] + 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (ctl.advance) begin
        v[k+1] <= v[k];
      end
      if (ctl.advance) begin
        r[k+1]  <= rn;
        d[k+1]  <= d[k];
        q[k+1]  <= qn;
        s[k+1]  <= s[k];
        sd[k+1] <= sd[k];
      end
    end
  end

  assign out_valid = v[ST];
  assign quot      = q[ST][FRAC:0];
  assign quot_neg  = s[ST];
  assign out_side  = sd[ST];

endmodule

// ===== rtl/q2r_front.sv =====
// q2r_front: sign-magnitude split, products, norm and numerators, three stages
// uses q2r_pkg
`timescale 1ns / 1ps
module q2r_front #(
  parameter int IW = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  q2r_pkg::stage_ctl_t ctl,
  input  logic                in_valid,
  input  logic [IW-1:0]       qx,
  input  logic [IW-1:0]       qy,
  input  logic [IW-1:0]       qz,
  input  logic [IW-1:0]       qw,
  output logic                out_valid,
  output logic [2*IW+1:0]     norm,
  output logic [2*IW+1:0]     num_mag [9],
  output logic [8:0]          num_neg,
  output logic                zero
);
  localparam int PW = 2 * IW;
  localparam int NW = 2 * IW + 2;

  // stage 1: magnitudes
  logic [IW-1:0] mag1 [4];
  logic [3:0]    sg1;
  logic          v1, v2, v3;
  logic [IW-1:0] raw [4];
  assign raw[0] = qx;
  assign raw[1] = qy;
  assign raw[2] = qz;
  assign raw[3] = qw;

  logic [IW-1:0] mg [4];
  logic [3:0]    sgn;
  logic          all_min;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sgn[i] = raw[i][IW-1];
      mg[i]  = sgn[i] ? (~raw[i] + 1'b1) : raw[i];
      if (mg[i] == '0) sgn[i] = 1'b0;
    end
    // all four at the most negative value: halve them, entries are unchanged
    all_min = (mg[0] == {1'b1, {(IW-1){1'b0}}}) && (mg[1] == mg[0]) &&
              (mg[2] == mg[0]) && (mg[3] == mg[0]);
    if (all_min)
      for (int i = 0; i < 4; i++) mg[i] = mg[i] >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (ctl.advance) v1 <= in_valid;
    if (ctl.advance) begin
      for (int i = 0; i < 4; i++) mag1[i] <= mg[i];
      sg1 <= sgn;
    end
  end

  // stage 2: the ten products
  logic [PW-1:0] sq2 [4];
  logic [PW-1:0] pxy, pxz, pyz, pwx, pwy, pwz;
  logic [3:0]    sg2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (ctl.advance) v2 <= v1;
    if (ctl.advance) begin
      for (int i = 0; i < 4; i++) sq2[i] <= mag1[i] * mag1[i];
      pxy <= mag1[0] * mag1[1];
      pxz <= mag1[0] * mag1[2];
      pyz <= mag1[1] * mag1[2];
      pwx <= mag1[3] * mag1[0];
      pwy <= mag1[3] * mag1[1];
      pwz <= mag1[3] * mag1[2];
      sg2 <= sg1;
    end
  end

  // stage 3: norm and signed numerators, kept in signed form of NW+1 bits
  typedef logic signed [NW:0] sv_t;
  function automatic sv_t sgx(input logic [PW-1:0] p, input logic neg);
    sv_t t;
    t = sv_t'({{(NW+1-PW){1'b0}}, p});
    return neg ? -t : t;
  endfunction

  sv_t e [9];
  always_comb begin
    sv_t a, b;
    a = sv_t'({{(NW+1-PW){1'b0}}, sq2[0]});
    b = sv_t'({{(NW+1-PW){1'b0}}, sq2[1]});
    e[0] = sgx(sq2[0], 1'b0) + sgx(sq2[3], 1'b0) - sgx(sq2[1], 1'b0) - sgx(sq2[2], 1'b0);
    e[4] = sgx(sq2[1], 1'b0) + sgx(sq2[3], 1'b0) - a - sgx(sq2[2], 1'b0);
    e[8] = sgx(sq2[2], 1'b0) + sgx(sq2[3], 1'b0) - a - b;
    e[1] = (sgx(pxy, sg2[0] ^ sg2[1]) + sgx(pwz, sg2[3] ^ sg2[2])) <<< 1;
    e[3] = (sgx(pxy, sg2[0] ^ sg2[1]) - sgx(pwz, sg2[3] ^ sg2[2])) <<< 1;
    e[2] = (sgx(pxz, sg2[0] ^ sg2[2]) - sgx(pwy, sg2[3] ^ sg2[1])) <<< 1;
    e[6] = (sgx(pxz, sg2[0] ^ sg2[2]) + sgx(pwy, sg2[3] ^ sg2[1])) <<< 1;
    e[5] = (sgx(pyz, sg2[1] ^ sg2[2]) + sgx(pwx, sg2[3] ^ sg2[0])) <<< 1;
    e[7] = (sgx(pyz, sg2[1] ^ sg2[2]) - sgx(pwx, sg2[3] ^ sg2[0])) <<< 1;
  end

  logic [NW-1:0] n_sum;
  assign n_sum = NW'(sq2[0]) + NW'(sq2[1]) + NW'(sq2[2]) + NW'(sq2[3]);

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (ctl.advance) v3 <= v2;
    if (ctl.advance) begin
      norm <= n_sum;
      zero <= (n_sum == '0);
      for (int i = 0; i < 9; i++) begin
        num_neg[i] <= e[i][NW];
        num_mag[i] <= e[i][NW] ? NW'(-e[i]) : e[i][NW-1:0];
      end
    end
  end

  assign out_valid = v3;

endmodule

// ===== dv/quaternion_to_rotation_matrix_tb.sv =====
// quaternion_to_rotation_matrix_tb: self-checking bench for the quaternion block
// depends on q2r_pkg and quaternion_to_rotation_matrix
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix_tb;

  localparam int FRAC = 14;
  localparam int N_RANDOM = 400;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  q2r_pkg::quat_t   in_data;
  logic             out_valid;
  logic             out_ready;
  q2r_pkg::matrix_t out_data;

  quaternion_to_rotation_matrix #(.OUT_FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  q2r_pkg::quat_t   quat_queue[$];
  q2r_pkg::matrix_t matrix_queue[$];
  int      mismatches = 0;
  int      words_in = 0;
  int      words_out = 0;
  int      zero_seen = 0;
  bit      stim_done = 0;
  bit      in_taken = 0;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // rounded |num| * 2^FRAC / n, ties away from zero, with the sign of num
  function automatic logic [15:0] scaled_entry(longint num, longint n);
    longint mag;
    longint q;
    longint r;
    mag = (num < 0) ? -num : num;
    q = (mag << FRAC) / n;
    r = (mag << FRAC) % n;
    if (2 * r >= n) q = q + 1;
    if (num < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic q2r_pkg::matrix_t predict_matrix(q2r_pkg::quat_t q);
    q2r_pkg::matrix_t m;
    longint x, y, z, w, n;
    x = q.quat_x; y = q.quat_y; z = q.quat_z; w = q.quat_w;
    n = x*x + y*y + z*z + w*w;
    m = '0;
    if (n == 0) begin
      m.col0_row0 = 16'sd16384;
      m.col1_row1 = 16'sd16384;
      m.col2_row2 = 16'sd16384;
      m.zero_norm = 1'b1;
      return m;
    end
    m.col0_row0 = scaled_entry(x*x + w*w - y*y - z*z, n);
    m.col0_row1 = scaled_entry(2*(x*y + w*z), n);
    m.col0_row2 = scaled_entry(2*(x*z - w*y), n);
    m.col1_row0 = scaled_entry(2*(x*y - w*z), n);
    m.col1_row1 = scaled_entry(y*y + w*w - x*x - z*z, n);
    m.col1_row2 = scaled_entry(2*(y*z + w*x), n);
    m.col2_row0 = scaled_entry(2*(x*z + w*y), n);
    m.col2_row1 = scaled_entry(2*(y*z - w*x), n);
    m.col2_row2 = scaled_entry(z*z + w*w - x*x - y*y, n);
    return m;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at word %0d: %s got %0d expected %0d", words_out, what, got, want);
    mismatches++;
  endtask

  function automatic logic [15:0] pick_component();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_quat(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [15:0] w);
    q2r_pkg::quat_t q;
    q.quat_x = x; q.quat_y = y; q.quat_z = z; q.quat_w = w;
    quat_queue.push_back(q);
  endtask

  // stimulus: directed corners, then random quaternions
  initial begin
    push_quat(0, 0, 0, 0);
    push_quat(0, 0, 0, 16'h7fff);
    push_quat(16'h7fff, 0, 0, 0);
    push_quat(0, 16'h8000, 0, 0);
    push_quat(0, 0, 16'h8000, 0);
    push_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    push_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    push_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    push_quat(1, 1, 1, 1);
    push_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    push_quat(1, 0, 0, 0);
    push_quat(0, 0, 0, 16'hffff);
    push_quat(1, 2, 3, 4);
    push_quat(16'hfffd, 5, 16'hfff9, 2);
    push_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    push_quat(0, 0, 0, 0);
    // small magnitudes with norms of 2 and 3
    push_quat(1, 1, 0, 0);
    push_quat(1, 0, 1, 1);
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 39) == 0) push_quat(0, 0, 0, 0);
      else push_quat(pick_component(), pick_component(), pick_component(), pick_component());
    end
    stim_done = 1;
  end

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the word until taken
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (quat_queue.size() > 0) begin
      in_valid <= 1'b1;
      in_data <= quat_queue.pop_front();
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 20);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall pattern: alternating ready and stall runs
  int stall_count = 0;
  bit stall_phase = 0;
  always @(negedge clk) begin
    if (stall_count == 0) begin
      stall_phase = ~stall_phase;
      stall_count = stall_phase ? $urandom_range(0, 5) : $urandom_range(1, 30);
    end else begin
      stall_count--;
    end
    out_ready <= rst ? 1'b0 : !stall_phase;
  end

  // monitor
  always @(posedge clk) begin
    q2r_pkg::matrix_t want;
    in_taken = !rst && in_valid && in_ready;
    if (in_taken) begin
      matrix_queue.push_back(predict_matrix(in_data));
      words_in++;
    end
    if (!rst && out_valid && out_ready) begin
      if (matrix_queue.size() == 0) begin
        $display("unexpected word from block");
        mismatches++;
      end else begin
        want = matrix_queue.pop_front();
        if (out_data.col0_row0 !== want.col0_row0)
          report("col0_row0", out_data.col0_row0, want.col0_row0);
        if (out_data.col0_row1 !== want.col0_row1)
          report("col0_row1", out_data.col0_row1, want.col0_row1);
        if (out_data.col0_row2 !== want.col0_row2)
          report("col0_row2", out_data.col0_row2, want.col0_row2);
        if (out_data.col1_row0 !== want.col1_row0)
          report("col1_row0", out_data.col1_row0, want.col1_row0);
        if (out_data.col1_row1 !== want.col1_row1)
          report("col1_row1", out_data.col1_row1, want.col1_row1);
        if (out_data.col1_row2 !== want.col1_row2)
          report("col1_row2", out_data.col1_row2, want.col1_row2);
        if (out_data.col2_row0 !== want.col2_row0)
          report("col2_row0", out_data.col2_row0, want.col2_row0);
        if (out_data.col2_row1 !== want.col2_row1)
          report("col2_row1", out_data.col2_row1, want.col2_row1);
        if (out_data.col2_row2 !== want.col2_row2)
          report("col2_row2", out_data.col2_row2, want.col2_row2);
        if (out_data.zero_norm !== want.zero_norm)
          report("zero_norm", out_data.zero_norm, want.zero_norm);
        if (want.zero_norm) zero_seen++;
      end
      words_out++;
    end
  end

  initial begin
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && quat_queue.size() == 0 && !in_valid);
    wait (matrix_queue.size() == 0);
    repeat (40) @(posedge clk);
    $display("%0d quaternions sent, %0d matrices checked, %0d of them zero norm",
             words_in, words_out, zero_seen);
    if (mismatches == 0 && matrix_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d words outstanding", matrix_queue.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
